// ----- hw/rtl/http_request_line_parser_defines.svh -----
// Assertion macros shared by the request line parser RTL.
`ifndef HTTP_REQUEST_LINE_PARSER_DEFINES_SVH
`define HTTP_REQUEST_LINE_PARSER_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define HRLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define HRLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HRLP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/http_rlp_pkg.sv -----
// Shared types and constants of the request line parser.
package http_rlp_pkg;

  // Byte kinds of a result item
  localparam logic [1:0] KIND_PATH    = 2'd0;
  localparam logic [1:0] KIND_QUERY   = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  // Verdict codes
  localparam logic [1:0] VRD_OK     = 2'd0;
  localparam logic [1:0] VRD_BAD    = 2'd1;  // 400
  localparam logic [1:0] VRD_NOTSUP = 2'd2;  // 501

  // Method codes
  localparam logic [1:0] MTH_NONE = 2'd0;
  localparam logic [1:0] MTH_GET  = 2'd1;
  localparam logic [1:0] MTH_HEAD = 2'd2;
  localparam logic [1:0] MTH_POST = 2'd3;

  // Method prefixes, first character in the top byte
  localparam logic [39:0] TXT_GET  = {"GET ", 8'h00};
  localparam logic [39:0] TXT_HEAD = "HEAD ";
  localparam logic [39:0] TXT_POST = "POST ";
  localparam logic [2:0]  LEN_GET  = 3'd4;
  localparam logic [2:0]  LEN_LONG = 3'd5;

  // Characters with a meaning in the target
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_P     = 8'h50;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] byte_kind;
    logic [1:0] method_code;
    logic [1:0] verdict;
    logic [7:0] path_count;
    logic       run_last;
  } out_item_t;

  // Up to two items produced by one input transfer
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  item_a;
    out_item_t  item_b;
  } push_t;

endpackage

// ----- hw/rtl/http_rlp_in_if.sv -----
// Input channel: request line bytes with a last-byte flag.
interface http_rlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       line_last;

  modport source (output valid, rx_byte, line_last, input ready);
  modport sink   (input valid, rx_byte, line_last, output ready);
endinterface

// ----- hw/rtl/http_rlp_out_if.sv -----
// Result channel: path, query and verdict items.
interface http_rlp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] byte_kind;
  logic [1:0] method_code;
  logic [1:0] verdict;
  logic [7:0] path_count;
  logic       run_last;

  modport source (output valid, out_byte, byte_kind, method_code, verdict, path_count,
                  run_last, input ready);
  modport sink   (input valid, out_byte, byte_kind, method_code, verdict, path_count,
                  run_last, output ready);
endinterface

// ----- hw/rtl/http_request_line_parser.sv -----
// Top level of the HTTP request line parser with percent decoding.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    rx_byte, line_last
//   out_ch   out  valid/ready    out_byte, byte_kind, method_code, verdict,
//                                path_count, run_last
//
// One input byte per cycle while ready is high; each byte yields zero, one or
// two result items (two only on the last byte of a line that also emits a
// path/query byte). The parse step is one level of logic from the input port
// into a 4-entry result queue; ready is high while the queue holds two or fewer
// items. Reset is synchronous, active low, and clears the parse state and queue.
// An output stall backs up the queue and then drops ready; no item is lost.
module http_request_line_parser #(
  parameter int PATH_MAX = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  http_rlp_in_if.sink     in_ch,
  http_rlp_out_if.source  out_ch
);

  http_rlp_pkg::push_t push;
  logic                space_ok;

  http_rlp_core #(
    .PATH_MAX (PATH_MAX)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .space_ok (space_ok),
    .push     (push)
  );

  http_rlp_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (space_ok),
    .out_ch   (out_ch)
  );

endmodule

// ----- hw/rtl/http_rlp_core.sv -----
// Per-byte parse state machine: method match, path decode, query pass-through.
`include "http_request_line_parser_defines.svh"

module http_rlp_core #(
  parameter int PATH_MAX = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  http_rlp_in_if.sink          in_ch,
  input  logic                 space_ok,
  output http_rlp_pkg::push_t  push
);

  localparam int PLEN_W = $clog2(PATH_MAX);
  localparam int EXT_W  = PLEN_W + 8;

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_FIRST,
    PH_PATH,
    PH_QUERY,
    PH_DONE
  } phase_t;

  phase_t            phase_r,       phase_nxt;
  logic [2:0]        match_pos_r,   match_pos_nxt;
  logic [1:0]        cand_r,        cand_nxt;
  logic [1:0]        method_r,      method_nxt;
  logic [1:0]        verdict_r,     verdict_nxt;
  logic [PLEN_W-1:0] path_len_r,    path_len_nxt;
  logic              dot_r,         dot_nxt;
  logic [1:0]        hex_step_r,    hex_step_nxt;
  logic [3:0]        hex_high_r,    hex_high_nxt;

  // Values after this byte, before the end-of-line clear
  phase_t            phase_m;
  logic [1:0]        method_m;
  logic [1:0]        verdict_m;
  logic [PLEN_W-1:0] path_len_m;
  logic              data_emit;
  logic [7:0]        data_byte;
  logic [1:0]        data_kind;
  logic [1:0]        final_verdict;
  logic [1:0]        final_method;
  logic [EXT_W-1:0]  len_ext;

  logic       fire;
  logic [7:0] b;
  logic       last;
  logic       ends;
  logic       do_token;
  logic [4:0] nib;
  logic       meth_ok;
  logic [2:0] meth_len;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= "0" && c <= "9") begin
      v = {1'b0, c[3:0]};
    end else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
      v = {1'b0, 4'(c[3:0] + 4'd9)};
    end
    return v;
  endfunction

  function automatic logic [7:0] meth_char(input logic [1:0] m, input logic [2:0] pos);
    logic [39:0] txt;
    logic [5:0]  sh;
    case (m)
      http_rlp_pkg::MTH_GET:  txt = http_rlp_pkg::TXT_GET;
      http_rlp_pkg::MTH_HEAD: txt = http_rlp_pkg::TXT_HEAD;
      http_rlp_pkg::MTH_POST: txt = http_rlp_pkg::TXT_POST;
      default:                txt = '0;
    endcase
    sh = 6'(32) - 6'({pos, 3'b000});
    return txt[sh +: 8];
  endfunction

  assign in_ch.ready = space_ok;
  assign fire        = in_ch.valid & space_ok;
  assign b           = in_ch.rx_byte;
  assign last        = in_ch.line_last;
  assign ends        = (b == http_rlp_pkg::CH_SPACE) || (b == http_rlp_pkg::CH_NUL);
  assign nib         = hex_val(b);

  // Step the parse for one byte
  always_comb begin
    phase_m       = phase_r;
    match_pos_nxt = match_pos_r;
    cand_nxt      = cand_r;
    method_m      = method_r;
    verdict_m     = verdict_r;
    path_len_m    = path_len_r;
    dot_nxt       = dot_r;
    hex_step_nxt  = hex_step_r;
    hex_high_nxt  = hex_high_r;
    data_emit     = 1'b0;
    data_byte     = b;
    data_kind     = http_rlp_pkg::KIND_PATH;
    do_token      = 1'b0;
    meth_ok       = 1'b0;
    meth_len      = http_rlp_pkg::LEN_LONG;

    case (phase_r)
      PH_METHOD: begin
        if (match_pos_r == 3'd0) begin
          meth_ok       = 1'b1;
          match_pos_nxt = 3'd1;
          if (b == http_rlp_pkg::CH_G) begin
            cand_nxt = http_rlp_pkg::MTH_GET;
          end else if (b == http_rlp_pkg::CH_H) begin
            cand_nxt = http_rlp_pkg::MTH_HEAD;
          end else if (b == http_rlp_pkg::CH_P) begin
            cand_nxt = http_rlp_pkg::MTH_POST;
          end else begin
            meth_ok       = 1'b0;
            match_pos_nxt = match_pos_r;
            verdict_m     = http_rlp_pkg::VRD_NOTSUP;
            phase_m       = PH_DONE;
          end
        end else if (b != meth_char(cand_r, match_pos_r)) begin
          cand_nxt  = http_rlp_pkg::MTH_NONE;
          verdict_m = http_rlp_pkg::VRD_NOTSUP;
          phase_m   = PH_DONE;
        end else begin
          meth_ok       = 1'b1;
          match_pos_nxt = match_pos_r + 3'd1;
        end
        meth_len = (cand_nxt == http_rlp_pkg::MTH_GET) ? http_rlp_pkg::LEN_GET
                                                       : http_rlp_pkg::LEN_LONG;
        if (meth_ok && match_pos_nxt >= meth_len) begin
          method_m = cand_nxt;
          phase_m  = PH_FIRST;
        end
      end
      PH_FIRST: begin
        if (b != http_rlp_pkg::CH_SLASH) begin
          verdict_m = http_rlp_pkg::VRD_BAD;
          phase_m   = PH_DONE;
        end else begin
          phase_m  = PH_PATH;
          do_token = 1'b1;
        end
      end
      PH_PATH: begin
        if (hex_step_r == 2'd1) begin
          if (ends || nib[4] || last) begin
            hex_step_nxt = 2'd0;
            phase_m      = PH_DONE;
          end else begin
            hex_high_nxt = nib[3:0];
            hex_step_nxt = 2'd2;
          end
        end else if (hex_step_r == 2'd2) begin
          hex_step_nxt = 2'd0;
          if (ends || nib[4] || {hex_high_r, nib[3:0]} == 8'h00) begin
            phase_m = PH_DONE;
          end else begin
            path_len_m = PLEN_W'(path_len_r + 1'b1);
            data_emit  = 1'b1;
            data_byte  = {hex_high_r, nib[3:0]};
          end
        end else if (ends) begin
          phase_m = PH_DONE;
        end else begin
          do_token = 1'b1;
        end
      end
      PH_QUERY: begin
        if (ends) begin
          phase_m = PH_DONE;
        end else begin
          data_emit = 1'b1;
          data_kind = http_rlp_pkg::KIND_QUERY;
        end
      end
      default: begin
      end
    endcase

    // Plain target byte: length limit, dot run, query and percent starts
    if (do_token) begin
      if (path_len_r >= PLEN_W'(PATH_MAX - 1)) begin
        verdict_m = http_rlp_pkg::VRD_BAD;
        phase_m   = PH_DONE;
      end else if (b == http_rlp_pkg::CH_DOT && dot_r) begin
        verdict_m = http_rlp_pkg::VRD_BAD;
        phase_m   = PH_DONE;
      end else begin
        dot_nxt = (b == http_rlp_pkg::CH_DOT);
        if (b == http_rlp_pkg::CH_QMARK) begin
          phase_m = PH_QUERY;
        end else if (b == http_rlp_pkg::CH_PCT) begin
          if (last) begin
            phase_m = PH_DONE;
          end else begin
            hex_step_nxt = 2'd1;
          end
        end else begin
          path_len_m = PLEN_W'(path_len_r + 1'b1);
          data_emit  = 1'b1;
        end
      end
    end
  end

  // Resolve the verdict for a line that ends here
  always_comb begin
    final_verdict = verdict_m;
    final_method  = method_m;
    if (phase_m == PH_METHOD) begin
      final_method  = http_rlp_pkg::MTH_NONE;
      final_verdict = http_rlp_pkg::VRD_NOTSUP;
    end else if (phase_m == PH_FIRST) begin
      final_verdict = http_rlp_pkg::VRD_BAD;
    end
  end

  // Clear the line state after the last byte
  always_comb begin
    phase_nxt    = phase_m;
    method_nxt   = method_m;
    verdict_nxt  = verdict_m;
    path_len_nxt = path_len_m;
    if (last) begin
      phase_nxt    = PH_METHOD;
      method_nxt   = http_rlp_pkg::MTH_NONE;
      verdict_nxt  = http_rlp_pkg::VRD_OK;
      path_len_nxt = '0;
    end
  end

  // Build the pushed items: data byte first, verdict after it
  assign len_ext = EXT_W'(path_len_m);

  always_comb begin
    http_rlp_pkg::out_item_t data_it;
    http_rlp_pkg::out_item_t vrd_it;
    data_it.out_byte    = data_byte;
    data_it.byte_kind   = data_kind;
    data_it.method_code = method_m;
    data_it.verdict     = http_rlp_pkg::VRD_OK;
    data_it.path_count  = len_ext[7:0];
    data_it.run_last    = 1'b0;
    vrd_it.out_byte     = 8'h00;
    vrd_it.byte_kind    = http_rlp_pkg::KIND_VERDICT;
    vrd_it.method_code  = final_method;
    vrd_it.verdict      = final_verdict;
    vrd_it.path_count   = len_ext[7:0];
    vrd_it.run_last     = 1'b1;

    push.item_a = data_emit ? data_it : vrd_it;
    push.item_b = vrd_it;
    push.cnt    = fire ? (2'(data_emit) + 2'(last)) : 2'd0;
  end

  // Hold state and advance on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_METHOD;
      match_pos_r <= '0;
      cand_r      <= http_rlp_pkg::MTH_NONE;
      method_r    <= http_rlp_pkg::MTH_NONE;
      verdict_r   <= http_rlp_pkg::VRD_OK;
      path_len_r  <= '0;
      dot_r       <= 1'b0;
      hex_step_r  <= '0;
      hex_high_r  <= '0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      method_r    <= method_nxt;
      verdict_r   <= verdict_nxt;
      path_len_r  <= path_len_nxt;
      if (last) begin
        match_pos_r <= '0;
        cand_r      <= http_rlp_pkg::MTH_NONE;
        dot_r       <= 1'b0;
        hex_step_r  <= '0;
        hex_high_r  <= '0;
      end else begin
        match_pos_r <= match_pos_nxt;
        cand_r      <= cand_nxt;
        dot_r       <= dot_nxt;
        hex_step_r  <= hex_step_nxt;
        hex_high_r  <= hex_high_nxt;
      end
    end
  end

  `HRLP_ASSERT_IMP(a_first_has_method, phase_r == PH_FIRST, method_r != http_rlp_pkg::MTH_NONE, "target phase without a matched method")

endmodule

// ----- hw/rtl/http_rlp_outq.sv -----
// Four-entry result queue that decouples the parser from the result channel.
`include "http_request_line_parser_defines.svh"

module http_rlp_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  http_rlp_pkg::push_t push,
  output logic                space_ok,
  http_rlp_out_if.source      out_ch
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  http_rlp_pkg::out_item_t mem_r [DEPTH];
  logic [PTR_W-1:0]        head_r, head_nxt;
  logic [PTR_W-1:0]        tail_r, tail_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    pop;
  logic [PTR_W-1:0]        tail_p1;

  // Room for two items keeps a full transfer from ever overflowing
  assign space_ok = (count_r <= CNT_W'(DEPTH - 2));
  assign pop      = out_ch.valid & out_ch.ready;
  assign tail_p1  = PTR_W'(tail_r + 1'b1);

  assign out_ch.valid       = (count_r != '0);
  assign out_ch.out_byte    = mem_r[head_r].out_byte;
  assign out_ch.byte_kind   = mem_r[head_r].byte_kind;
  assign out_ch.method_code = mem_r[head_r].method_code;
  assign out_ch.verdict     = mem_r[head_r].verdict;
  assign out_ch.path_count  = mem_r[head_r].path_count;
  assign out_ch.run_last    = mem_r[head_r].run_last;

  always_comb begin
    head_nxt  = pop ? PTR_W'(head_r + 1'b1) : head_r;
    tail_nxt  = PTR_W'(tail_r + push.cnt);
    count_nxt = CNT_W'(count_r + push.cnt - CNT_W'(pop));
  end

  // Write the pushed items at the tail
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[tail_r] <= push.item_a;
    end
    if (push.cnt == 2'd2) begin
      mem_r[tail_p1] <= push.item_b;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  `HRLP_ASSERT(a_count_max, count_r <= CNT_W'(DEPTH), "result queue count exceeds depth")
  `HRLP_ASSERT_IMP(a_push_room, push.cnt != 2'd0, space_ok && push.cnt != 2'd3, "push without room")
  `HRLP_ASSERT_NXT(a_push_two, push.cnt == 2'd2 && !pop, count_r == $past(count_r) + 3'd2, "double push lost an item")

endmodule

// ----- tb/sv/http_request_line_parser_test.sv -----
// Self-checking testbench for the HTTP request line parser with percent decoding.
`timescale 1ns / 100ps

module http_request_line_parser_test;

  localparam int PATH_LIMIT  = 256;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;

  typedef enum logic [2:0] {PS_METHOD, PS_FIRST, PS_PATH, PS_QUERY, PS_DONE} parse_phase_t;
  typedef enum logic [1:0] {HX_NONE, HX_HIGH, HX_LOW} hex_step_t;

  logic clk = 1'b0;
  logic rst_n;

  http_rlp_in_if  in_ch();
  http_rlp_out_if out_ch();

  http_request_line_parser #(.PATH_MAX(PATH_LIMIT)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Parser state as predicted from the accepted bytes
  parse_phase_t ph;
  hex_step_t    hex_step;
  logic [2:0]   match_pos;
  logic [1:0]   cand;
  logic [1:0]   method_seen;
  logic [1:0]   verdict_held;
  int           path_len;
  logic         dot_pending;
  logic [3:0]   hex_high;

  http_rlp_pkg::out_item_t decoded_q[$];
  logic [7:0] line_buf[$];
  int         mismatch_count = 0;
  int         quiet_cycles = 0;
  int         bytes_sent = 0;
  int         burst_left = 0;
  int         hold_req_cnt = 0;

  function automatic logic [7:0] method_char(logic [1:0] m, int pos);
    logic [39:0] txt;
    case (m)
      http_rlp_pkg::MTH_GET:  txt = http_rlp_pkg::TXT_GET;
      http_rlp_pkg::MTH_HEAD: txt = http_rlp_pkg::TXT_HEAD;
      default:                txt = http_rlp_pkg::TXT_POST;
    endcase
    return txt[39 - 8 * pos -: 8];
  endfunction

  function automatic logic [2:0] method_len(logic [1:0] m);
    return (m == http_rlp_pkg::MTH_GET) ? http_rlp_pkg::LEN_GET : http_rlp_pkg::LEN_LONG;
  endfunction

  // Hex digit value, 16 for anything that is not a digit
  function automatic logic [4:0] hex_value(logic [7:0] b);
    if (b >= "0" && b <= "9") return 5'(b - "0");
    if (b >= "A" && b <= "F") return 5'(b - "A" + 10);
    if (b >= "a" && b <= "f") return 5'(b - "a" + 10);
    return 5'd16;
  endfunction

  function automatic void clear_line();
    ph           = PS_METHOD;
    hex_step     = HX_NONE;
    match_pos    = '0;
    cand         = http_rlp_pkg::MTH_NONE;
    method_seen  = http_rlp_pkg::MTH_NONE;
    verdict_held = http_rlp_pkg::VRD_OK;
    path_len     = 0;
    dot_pending  = 1'b0;
    hex_high     = '0;
  endfunction

  function automatic void abort_line(logic [1:0] v);
    verdict_held = v;
    ph           = PS_DONE;
  endfunction

  function automatic void emit(logic [7:0] b, logic [1:0] kind, logic [1:0] vrd, logic lst);
    http_rlp_pkg::out_item_t it;
    it.out_byte    = b;
    it.byte_kind   = kind;
    it.method_code = method_seen;
    it.verdict     = vrd;
    it.path_count  = path_len[7:0];
    it.run_last    = lst;
    decoded_q.push_back(it);
  endfunction

  // One target byte outside a percent pair
  function automatic void path_token(logic [7:0] b, logic last);
    logic was_dot;
    was_dot = dot_pending;
    if (path_len >= PATH_LIMIT - 1) begin
      abort_line(http_rlp_pkg::VRD_BAD);
    end else if (b == http_rlp_pkg::CH_DOT && was_dot) begin
      abort_line(http_rlp_pkg::VRD_BAD);
    end else begin
      dot_pending = (b == http_rlp_pkg::CH_DOT);
      if (b == http_rlp_pkg::CH_QMARK) begin
        ph = PS_QUERY;
      end else if (b == http_rlp_pkg::CH_PCT) begin
        if (last) ph = PS_DONE;
        else hex_step = HX_HIGH;
      end else begin
        path_len++;
        emit(b, http_rlp_pkg::KIND_PATH, http_rlp_pkg::VRD_OK, 1'b0);
      end
    end
  endfunction

  // Advance the predicted parser by one accepted byte
  function automatic void parse_byte(logic [7:0] b, logic last);
    logic       ends;
    logic [4:0] nib;
    logic [7:0] dec;
    logic [1:0] vrd;
    ends = (b == http_rlp_pkg::CH_SPACE) || (b == http_rlp_pkg::CH_NUL);
    case (ph)
      PS_METHOD: begin
        if (match_pos == 0) begin
          if (b == http_rlp_pkg::CH_G) cand = http_rlp_pkg::MTH_GET;
          else if (b == http_rlp_pkg::CH_H) cand = http_rlp_pkg::MTH_HEAD;
          else if (b == http_rlp_pkg::CH_P) cand = http_rlp_pkg::MTH_POST;
          else abort_line(http_rlp_pkg::VRD_NOTSUP);
          if (ph == PS_METHOD) match_pos = 3'd1;
        end else if (b != method_char(cand, match_pos)) begin
          cand = http_rlp_pkg::MTH_NONE;
          abort_line(http_rlp_pkg::VRD_NOTSUP);
        end else begin
          match_pos++;
        end
        if (ph == PS_METHOD && match_pos >= method_len(cand)) begin
          method_seen = cand;
          ph = PS_FIRST;
        end
      end
      PS_FIRST: begin
        if (b != http_rlp_pkg::CH_SLASH) begin
          abort_line(http_rlp_pkg::VRD_BAD);
        end else begin
          ph = PS_PATH;
          path_token(b, last);
        end
      end
      PS_PATH: begin
        if (hex_step == HX_HIGH) begin
          nib = hex_value(b);
          if (ends || nib > 15 || last) begin
            hex_step = HX_NONE;
            ph = PS_DONE;
          end else begin
            hex_high = nib[3:0];
            hex_step = HX_LOW;
          end
        end else if (hex_step == HX_LOW) begin
          nib = hex_value(b);
          hex_step = HX_NONE;
          dec = {hex_high, nib[3:0]};
          if (ends || nib > 15 || dec == 8'h00) begin
            ph = PS_DONE;
          end else begin
            path_len++;
            emit(dec, http_rlp_pkg::KIND_PATH, http_rlp_pkg::VRD_OK, 1'b0);
          end
        end else if (ends) begin
          ph = PS_DONE;
        end else begin
          path_token(b, last);
        end
      end
      PS_QUERY: begin
        if (ends) ph = PS_DONE;
        else emit(b, http_rlp_pkg::KIND_QUERY, http_rlp_pkg::VRD_OK, 1'b0);
      end
      default: ;
    endcase
    // close the line with its verdict
    if (last) begin
      vrd = verdict_held;
      if (ph == PS_METHOD) begin
        method_seen = http_rlp_pkg::MTH_NONE;
        vrd = http_rlp_pkg::VRD_NOTSUP;
      end else if (ph == PS_FIRST) begin
        vrd = http_rlp_pkg::VRD_BAD;
      end
      emit(8'h00, http_rlp_pkg::KIND_VERDICT, vrd, 1'b1);
      clear_line();
    end
  endfunction

  // Predict on input transfers, check output transfers, watch for a hang
  always @(posedge clk) begin
    http_rlp_pkg::out_item_t got;
    http_rlp_pkg::out_item_t exp;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) parse_byte(in_ch.rx_byte, in_ch.line_last);
      if (out_ch.valid && out_ch.ready) begin
        got.out_byte    = out_ch.out_byte;
        got.byte_kind   = out_ch.byte_kind;
        got.method_code = out_ch.method_code;
        got.verdict     = out_ch.verdict;
        got.path_count  = out_ch.path_count;
        got.run_last    = out_ch.run_last;
        if (decoded_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected item, expected none, actual %h", $time, got);
        end else begin
          exp = decoded_q.pop_front();
          if (got !== exp) begin
            mismatch_count++;
            if (got.out_byte !== exp.out_byte)
              $display("%0t: out_byte expected %h actual %h", $time, exp.out_byte,
                       got.out_byte);
            if (got.byte_kind !== exp.byte_kind)
              $display("%0t: byte_kind expected %0d actual %0d", $time, exp.byte_kind,
                       got.byte_kind);
            if (got.method_code !== exp.method_code)
              $display("%0t: method_code expected %0d actual %0d", $time, exp.method_code,
                       got.method_code);
            if (got.verdict !== exp.verdict)
              $display("%0t: verdict expected %0d actual %0d", $time, exp.verdict,
                       got.verdict);
            if (got.path_count !== exp.path_count)
              $display("%0t: path_count expected %0d actual %0d", $time, exp.path_count,
                       got.path_count);
            if (got.run_last !== exp.run_last)
              $display("%0t: run_last expected %0d actual %0d", $time, exp.run_last,
                       got.run_last);
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // Receiver: stall patterns that change now and then, plus long hold-offs on request
  initial begin
    int hold_served;
    int hold_left;
    int mode;
    int mode_left;
    int pat_cnt;
    hold_served = 0;
    hold_left = 0;
    mode = 0;
    mode_left = 0;
    pat_cnt = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_req_cnt) begin
        hold_served = hold_req_cnt;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 100);
        end
        mode_left--;
        pat_cnt++;
        case (mode)
          0: out_ch.ready = 1'b1;
          1: out_ch.ready = ($urandom_range(0, 3) != 0);
          2: out_ch.ready = ($urandom_range(0, 1) != 0);
          default: out_ch.ready = ((pat_cnt % 5) < 3);
        endcase
      end
    end
  end

  // Offer one byte and hold it until it is taken; bursts with random gaps
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 24);
    end
    @(negedge clk);
    in_ch.valid     = 1'b1;
    in_ch.rx_byte   = b;
    in_ch.line_last = last;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_byte(line_buf[i], i == line_buf.size() - 1);
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  task automatic send_text(input string s);
    line_buf.delete();
    push_text(s);
    send_line();
  endtask

  function automatic logic [7:0] hex_digit();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return 8'("0" + v);
    if (v < 16) return 8'("A" + v - 10);
    return 8'("a" + v - 16);
  endfunction

  // Build one request line: mostly well formed, some broken, some pure noise
  function automatic void build_request();
    int sel;
    int n;
    int kind;
    int cut;
    logic [1:0] m;
    logic [2:0] mlen;
    line_buf.delete();
    if ($urandom_range(0, 99) < 10) begin
      n = $urandom_range(1, 10);
      repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    m = 2'($urandom_range(1, 3));
    mlen = method_len(m);
    for (int i = 0; i < mlen; i++) line_buf.push_back(method_char(m, i));
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      // line cut short inside the method
      cut = $urandom_range(1, mlen - 1);
      while (line_buf.size() > cut) void'(line_buf.pop_back());
      return;
    end else if (sel < 9) begin
      line_buf[$urandom_range(0, mlen - 1)] = 8'($urandom_range(0, 255));
    end else if (sel < 11) begin
      line_buf[0] = line_buf[0] | 8'h20;
    end
    sel = $urandom_range(0, 99);
    if (sel < 5) return;
    if (sel < 10) line_buf.push_back(8'($urandom_range(0, 255)));
    else line_buf.push_back(http_rlp_pkg::CH_SLASH);
    n = $urandom_range(0, 14);
    repeat (n) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        line_buf.push_back(8'($urandom_range(33, 126)));
      end else if (kind < 58) begin
        line_buf.push_back(http_rlp_pkg::CH_DOT);
      end else if (kind < 63) begin
        push_text("..");
      end else if (kind < 78) begin
        line_buf.push_back(http_rlp_pkg::CH_PCT);
        line_buf.push_back(hex_digit());
        line_buf.push_back(hex_digit());
      end else if (kind < 83) begin
        line_buf.push_back(http_rlp_pkg::CH_PCT);
        if ($urandom_range(0, 1)) line_buf.push_back(hex_digit());
        line_buf.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 86) begin
        push_text("%00");
      end else if (kind < 90) begin
        line_buf.push_back(http_rlp_pkg::CH_PCT);
      end else if (kind < 95) begin
        line_buf.push_back(http_rlp_pkg::CH_QMARK);
      end else begin
        line_buf.push_back(8'($urandom_range(0, 255)));
      end
    end
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      push_text(" HTTP/1.1");
    end else if (sel < 65) begin
      line_buf.push_back(http_rlp_pkg::CH_SPACE);
      repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // Directed special cases, each once with a known line
  task automatic test_directed();
    send_text("Q");
    send_text("HEA");
    send_text("GET ");
    send_text("POST /%41?x");
    send_text("GET /..");
  endtask

  task automatic test_random_requests(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      build_request();
      send_line();
    end
  endtask

  // Long receiver hold-off while the sender keeps offering; the block must stall its input
  task automatic test_output_hold();
    hold_req_cnt++;
    line_buf.delete();
    push_text("GET /");
    repeat (30) line_buf.push_back(8'("a" + $urandom_range(0, 25)));
    push_text("?q=1 HTTP/1.1");
    send_line();
    repeat (3) begin
      build_request();
      send_line();
    end
  endtask

  // Sender pauses until every outstanding item is out, then resumes
  task automatic test_drain_pause();
    go_idle();
    wait_drained();
    build_request();
    send_line();
  endtask

  // Path length limit: a decoded pair fills the path, the next target byte is refused
  task automatic test_path_limit();
    line_buf.delete();
    push_text("HEAD /");
    repeat (253) line_buf.push_back(8'("a" + $urandom_range(0, 25)));
    push_text("%41%42 HTTP/1.1");
    send_line();
  endtask

  initial begin
    clear_line();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    in_ch.line_last = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_requests(60);
    test_output_hold();
    test_drain_pause();
    test_path_limit();
    test_random_requests(60);

    // drain, then wait for any stray item
    go_idle();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && decoded_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
